// File: rtl/epbt_pkg.sv
// Shared constants and result type for the edge pixel boundary term core.
`default_nettype none

package epbt_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_WIDTH   = 48;
  localparam int OUT_FRAC    = 24;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] term_start_moving;
    logic signed [OUT_WIDTH-1:0] term_end_moving;
    logic signed [OUT_WIDTH-1:0] term_translating;
    logic                        crosses_pixel;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/epbt_edge_if.sv
// Input channel carrying one edge beat with its direction and shading values.
`default_nettype none

interface epbt_edge_if #(
  parameter int COORD_WIDTH = epbt_pkg::COORD_WIDTH
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] inside_value;
  logic signed [COORD_WIDTH-1:0] outside_value;

  modport source (
    output valid, start_x, start_y, end_x, end_y, dir_x, dir_y, inside_value, outside_value,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y, dir_x, dir_y, inside_value, outside_value,
    output ready
  );

endinterface

`default_nettype wire

// File: rtl/epbt_term_if.sv
// Output channel carrying the three boundary terms and the crossing flag of one beat.
`default_nettype none

interface epbt_term_if ();

  logic                                  valid;
  logic                                  ready;
  logic signed [epbt_pkg::OUT_WIDTH-1:0] term_start_moving;
  logic signed [epbt_pkg::OUT_WIDTH-1:0] term_end_moving;
  logic signed [epbt_pkg::OUT_WIDTH-1:0] term_translating;
  logic                                  crosses_pixel;

  modport source (
    output valid, term_start_moving, term_end_moving, term_translating, crosses_pixel,
    input  ready
  );

  modport sink (
    input  valid, term_start_moving, term_end_moving, term_translating, crosses_pixel,
    output ready
  );

endinterface

`default_nettype wire

// File: rtl/edge_pixel_boundary_term_core.sv
// Top level of the edge pixel boundary term core.
// The core clips one edge per beat to the unit pixel by Liang-Barsky and returns the
// start-moving, end-moving and translating boundary terms in 24 fraction bits, saturated
// to 48 bits, with a flag telling whether the clipped chord is nonempty. It accepts one
// beat every clock while the output buffer has room and returns one result per beat in order.
// Each beat passes the input stage, the four restoring divider lanes that produce one quotient
// bit per stage, then the weight, product and saturation stages and a two-entry output buffer.
// The whole pipeline holds while that buffer is full; one waiting result does not stop it.
`default_nettype none

module edge_pixel_boundary_term_core #(
  parameter int COORD_WIDTH = epbt_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = epbt_pkg::FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  epbt_edge_if.sink   edge_i,
  epbt_term_if.source term_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int QW  = ((CW > FB + 1) ? CW : FB + 2) + 1;
  localparam int WW  = FB + 1;
  localparam int JMW = CW + 1;
  localparam int PRW = 2 * CW + 1;
  localparam int DNW = 2 * CW + 1;
  localparam int JWW = JMW + WW;
  localparam logic [WW-1:0] ONE = WW'(1) << FB;

  typedef struct packed {
    logic [3:0]          lo;
    logic [3:0]          hi;
    logic [3:0]          tneg;
    logic                rej;
    logic signed [CW:0]  dx;
    logic signed [CW:0]  dy;
    logic signed [CW-1:0] ddx;
    logic signed [CW-1:0] ddy;
    logic signed [CW:0]  jmp;
  } side_t;

  logic en;

  // Input stage.
  logic                 va_q;
  logic signed [CW-1:0] sx_q, sy_q, ddx_q, ddy_q;
  logic signed [CW:0]   dx_q, dy_q, jmp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= edge_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q  <= edge_i.start_x;
      sy_q  <= edge_i.start_y;
      ddx_q <= edge_i.dir_x;
      ddy_q <= edge_i.dir_y;
      dx_q  <= (CW + 1)'(edge_i.end_x) - (CW + 1)'(edge_i.start_x);
      dy_q  <= (CW + 1)'(edge_i.end_y) - (CW + 1)'(edge_i.start_y);
      jmp_q <= (CW + 1)'(edge_i.inside_value) - (CW + 1)'(edge_i.outside_value);
    end
  end

  assign edge_i.ready = en;

  // Clip setup for the four sides.
  logic signed [QW-1:0] qv [4];
  logic [QW-1:0]        lane_a [4];
  logic [QW-1:0]        lane_b [4];
  logic [WW-1:0]        lane_q [4];
  logic [3:0]           qneg;
  logic [CW-1:0]        adx, ady;
  logic                 dxz, dyz, dxp, dxn, dyp, dyn;
  side_t                side_d;

  always_comb begin
    qv[0] = QW'(sx_q);
    qv[1] = QW'({1'b0, ONE}) - QW'(sx_q);
    qv[2] = QW'(sy_q);
    qv[3] = QW'({1'b0, ONE}) - QW'(sy_q);
    for (int i = 0; i < 4; i++) begin
      qneg[i]   = qv[i][QW-1];
      lane_a[i] = qneg[i] ? QW'(-qv[i]) : QW'(qv[i]);
    end
    adx = dx_q[CW] ? CW'(-dx_q) : CW'(dx_q);
    ady = dy_q[CW] ? CW'(-dy_q) : CW'(dy_q);
    lane_b[0] = QW'(adx);
    lane_b[1] = QW'(adx);
    lane_b[2] = QW'(ady);
    lane_b[3] = QW'(ady);
    dxz = dx_q == '0;
    dyz = dy_q == '0;
    dxn = dx_q[CW];
    dyn = dy_q[CW];
    dxp = !dxn && !dxz;
    dyp = !dyn && !dyz;
    side_d.lo   = {dyn, dyp, dxn, dxp};
    side_d.hi   = {dyp, dyn, dxp, dxn};
    side_d.tneg = qneg ^ {dyn, dyp, dxn, dxp};
    side_d.rej  = (dxz && dyz) || (dxz && (qneg[0] || qneg[1])) ||
                  (dyz && (qneg[2] || qneg[3]));
    side_d.dx   = dx_q;
    side_d.dy   = dy_q;
    side_d.ddx  = ddx_q;
    side_d.ddy  = ddy_q;
    side_d.jmp  = jmp_q;
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    epbt_div_lane #(
      .AW        (QW),
      .FRAC_BITS (FB)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (lane_a[i]),
      .b_i   (lane_b[i]),
      .q_o   (lane_q[i])
    );
  end

  // Side information travels alongside the divider lanes.
  side_t         sd_q [FB];
  logic [FB-1:0] vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
    end else if (en) begin
      vd_q <= {vd_q[FB-2:0], va_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= side_d;
      for (int j = 1; j < FB; j++) begin
        sd_q[j] <= sd_q[j-1];
      end
    end
  end

  // Chord limits, direction products and jump magnitude.
  side_t                 sd_o;
  logic [WW-1:0]         tsel [4];
  logic [WW-1:0]         ua_d, ub_d;
  logic                  v1_q, rej1_q, sj1_q;
  logic [WW-1:0]         ua1_q, ub1_q;
  logic signed [PRW-1:0] pr1_q, pr2_q;
  logic [JMW-1:0]        jm1_q;

  assign sd_o = sd_q[FB-1];

  always_comb begin
    ua_d = '0;
    ub_d = ONE;
    for (int i = 0; i < 4; i++) begin
      tsel[i] = sd_o.tneg[i] ? '0 : lane_q[i];
      if (sd_o.lo[i] && tsel[i] > ua_d) begin
        ua_d = tsel[i];
      end
      if (sd_o.hi[i] && tsel[i] < ub_d) begin
        ub_d = tsel[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ua1_q  <= ua_d;
      ub1_q  <= ub_d;
      rej1_q <= sd_o.rej;
      pr1_q  <= PRW'(sd_o.ddy) * PRW'(sd_o.dx);
      pr2_q  <= PRW'(sd_o.ddx) * PRW'(sd_o.dy);
      jm1_q  <= sd_o.jmp[CW] ? JMW'(-sd_o.jmp) : JMW'(sd_o.jmp);
      sj1_q  <= sd_o.jmp[CW];
    end
  end

  // Squares, chord length and normal term.
  logic signed [PRW:0] dnf;
  logic                v2_q, empty2_q, sd2_q, sj2_q;
  logic [2*WW-1:0]     ua2_q, ub2_q;
  logic [WW-1:0]       wt2_q;
  logic [DNW-1:0]      dnm2_q;
  logic [JMW-1:0]      jm2_q;

  assign dnf = (PRW + 1)'(pr1_q) - (PRW + 1)'(pr2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      empty2_q <= rej1_q || (ua1_q >= ub1_q);
      ua2_q    <= (2 * WW)'(ua1_q) * (2 * WW)'(ua1_q);
      ub2_q    <= (2 * WW)'(ub1_q) * (2 * WW)'(ub1_q);
      wt2_q    <= ub1_q - ua1_q;
      dnm2_q   <= dnf[PRW] ? DNW'(-dnf) : DNW'(dnf);
      sd2_q    <= dnf[PRW];
      jm2_q    <= jm1_q;
      sj2_q    <= sj1_q;
    end
  end

  // Chord weights.
  logic [2*WW-1:0] sq, wsf;
  logic            v3_q, crs3_q, neg3_q;
  logic [WW-1:0]   w3_q [3];
  logic [DNW-1:0]  dnm3_q;
  logic [JMW-1:0]  jm3_q;

  assign sq  = ub2_q - ua2_q;
  assign wsf = ((2 * WW)'(wt2_q) << (FB + 1)) - sq;

  always_ff @(posedge clk_i) begin
    if (en) begin
      w3_q[0] <= empty2_q ? '0 : WW'(wsf >> (FB + 1));
      w3_q[1] <= empty2_q ? '0 : WW'(sq >> (FB + 1));
      w3_q[2] <= empty2_q ? '0 : wt2_q;
      crs3_q  <= !empty2_q;
      neg3_q  <= sj2_q ^ sd2_q;
      dnm3_q  <= dnm2_q;
      jm3_q   <= jm2_q;
    end
  end

  // Weighted jumps.
  logic           v4_q, crs4_q, neg4_q;
  logic [JWW-1:0] jw4_q [3];
  logic [DNW-1:0] dnm4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        jw4_q[k] <= JWW'(jm3_q) * JWW'(w3_q[k]);
      end
      crs4_q <= crs3_q;
      neg4_q <= neg3_q;
      dnm4_q <= dnm3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= vd_q[FB-1];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Final products.
  logic signed [epbt_pkg::OUT_WIDTH-1:0] term_m [3];
  logic [3:0]                            vm_q, cm_q;

  for (genvar k = 0; k < 3; k++) begin : g_term
    epbt_term_mul #(
      .JW        (JWW),
      .DW        (DNW),
      .FRAC_BITS (FB)
    ) u_term (
      .clk_i  (clk_i),
      .en_i   (en),
      .jw_i   (jw4_q[k]),
      .dn_i   (dnm4_q),
      .neg_i  (neg4_q),
      .term_o (term_m[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= '0;
    end else if (en) begin
      vm_q <= {vm_q[2:0], v4_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cm_q <= {cm_q[2:0], crs4_q};
    end
  end

  epbt_pkg::result_t res_in, res_out;

  always_comb begin
    res_in.term_start_moving = term_m[0];
    res_in.term_end_moving   = term_m[1];
    res_in.term_translating  = term_m[2];
    res_in.crosses_pixel     = cm_q[3];
  end

  epbt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vm_q[3]),
    .in_data_i   (res_in),
    .room_o      (en),
    .out_valid_o (term_o.valid),
    .out_ready_i (term_o.ready),
    .out_data_o  (res_out)
  );

  assign term_o.term_start_moving = res_out.term_start_moving;
  assign term_o.term_end_moving   = res_out.term_end_moving;
  assign term_o.term_translating  = res_out.term_translating;
  assign term_o.crosses_pixel     = res_out.crosses_pixel;

endmodule

`default_nettype wire

// File: rtl/epbt_div_lane.sv
// Pipelined restoring divider giving min(floor(a * 2^FRAC_BITS / b), 2^FRAC_BITS).
`default_nettype none

module epbt_div_lane #(
  parameter int AW        = epbt_pkg::COORD_WIDTH + 1,
  parameter int FRAC_BITS = epbt_pkg::FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [AW-1:0]        a_i,
  input  logic [AW-1:0]        b_i,
  output logic [FRAC_BITS:0]   q_o
);

  localparam int FB = FRAC_BITS;
  localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

  logic [AW-1:0] rem_q [FB];
  logic [AW-1:0] div_q [FB];
  logic [FB-1:0] quo_q [FB];
  logic          sat_q [FB];

  for (genvar j = 0; j < FB; j++) begin : g_step
    logic [AW-1:0] r_prev;
    logic [AW-1:0] b_prev;
    logic [FB-1:0] qt_prev;
    logic          s_prev;
    logic [AW:0]   r2;
    logic          ge;

    if (j == 0) begin : g_first
      assign r_prev  = a_i;
      assign b_prev  = b_i;
      assign qt_prev = '0;
      assign s_prev  = a_i >= b_i;
    end else begin : g_next
      assign r_prev  = rem_q[j-1];
      assign b_prev  = div_q[j-1];
      assign qt_prev = quo_q[j-1];
      assign s_prev  = sat_q[j-1];
    end

    assign r2 = {r_prev, 1'b0};
    assign ge = r2 >= {1'b0, b_prev};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? AW'(r2 - {1'b0, b_prev}) : AW'(r2);
        div_q[j] <= b_prev;
        quo_q[j] <= {qt_prev[FB-2:0], ge};
        sat_q[j] <= s_prev;
      end
    end
  end

  assign q_o = sat_q[FB-1] ? ONE : {1'b0, quo_q[FB-1]};

endmodule

`default_nettype wire

// File: rtl/epbt_term_mul.sv
// Pipelined magnitude product of weighted jump and normal term, scaled, saturated and signed.
`default_nettype none

module epbt_term_mul #(
  parameter int JW        = epbt_pkg::COORD_WIDTH + epbt_pkg::FRAC_BITS + 2,
  parameter int DW        = 2 * epbt_pkg::COORD_WIDTH + 1,
  parameter int FRAC_BITS = epbt_pkg::FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [JW-1:0]                         jw_i,
  input  logic [DW-1:0]                         dn_i,
  input  logic                                  neg_i,
  output logic signed [epbt_pkg::OUT_WIDTH-1:0] term_o
);

  localparam int OW = epbt_pkg::OUT_WIDTH;
  localparam int JL = JW / 2;
  localparam int JH = JW - JL;
  localparam int DL = DW / 2;
  localparam int DH = DW - DL;
  localparam int MW = JW + DW;
  localparam int XW = MW + OW;
  localparam int TS = 4 * FRAC_BITS - epbt_pkg::OUT_FRAC;
  localparam logic [XW-1:0] NEG_LIM = XW'(1) << (OW - 1);
  localparam logic [XW-1:0] POS_LIM = NEG_LIM - XW'(1);

  logic [JL+DL-1:0] ll_q;
  logic [JL+DH-1:0] lh_q;
  logic [JH+DL-1:0] hl_q;
  logic [JH+DH-1:0] hh_q;
  logic             neg1_q, neg2_q, neg3_q;
  logic [MW-1:0]    s1_q, s2_q, m_q;
  logic [XW-1:0]    mx;
  logic [OW-1:0]    r;
  logic signed [OW-1:0] term_q;

  always_comb begin
    mx = XW'(m_q) >> TS;
    if (neg3_q) begin
      r = (mx > NEG_LIM) ? NEG_LIM[OW-1:0] : mx[OW-1:0];
    end else begin
      r = (mx > POS_LIM) ? POS_LIM[OW-1:0] : mx[OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q   <= (JL + DL)'(jw_i[JL-1:0]) * (JL + DL)'(dn_i[DL-1:0]);
      lh_q   <= (JL + DH)'(jw_i[JL-1:0]) * (JL + DH)'(dn_i[DW-1:DL]);
      hl_q   <= (JH + DL)'(jw_i[JW-1:JL]) * (JH + DL)'(dn_i[DL-1:0]);
      hh_q   <= (JH + DH)'(jw_i[JW-1:JL]) * (JH + DH)'(dn_i[DW-1:DL]);
      neg1_q <= neg_i;
      s1_q   <= MW'(ll_q) + (MW'(lh_q) << DL);
      s2_q   <= MW'(hl_q) + (MW'(hh_q) << DL);
      neg2_q <= neg1_q;
      m_q    <= s1_q + (s2_q << JL);
      neg3_q <= neg2_q;
      term_q <= neg3_q ? $signed(OW'(~r + 1'b1)) : $signed(r);
    end
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

// File: rtl/epbt_out_buf.sv
// Two-entry output buffer that decouples the pipeline from the result consumer.
`default_nettype none

module epbt_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  epbt_pkg::result_t in_data_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output epbt_pkg::result_t out_data_o
);

  logic [1:0]        cnt_q, cnt_d;
  logic              wp_q, rp_q;
  logic              push, pop;
  epbt_pkg::result_t mem_q [2];

  assign room_o      = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign push        = in_valid_i && room_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// File: tb/edge_pixel_boundary_term_core_tb.sv
// Self-checking testbench for the edge pixel boundary term core with a clip-and-term predictor.
`default_nettype none

module edge_pixel_boundary_term_core_tb;

  localparam int COORD_WIDTH = epbt_pkg::COORD_WIDTH;
  localparam int FRAC_BITS   = epbt_pkg::FRAC_BITS;
  localparam int OUT_WIDTH   = epbt_pkg::OUT_WIDTH;
  localparam int OUT_FRAC    = epbt_pkg::OUT_FRAC;

  typedef epbt_pkg::result_t result_t;

  localparam longint ONE        = 64'sd1 <<< FRAC_BITS;
  localparam int     TERM_SHIFT = 4 * FRAC_BITS - OUT_FRAC;
  localparam int     DRAIN_WAIT = FRAC_BITS + 40;
  localparam longint CYCLE_CAP  = 2000000;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] sx, sy, ex, ey, dirx, diry, vin, vout;
  } edge_beat_t;

  logic clk_i;
  logic rst_ni;

  epbt_edge_if edge_if ();
  epbt_term_if term_if ();

  edge_pixel_boundary_term_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .edge_i (edge_if),
    .term_o (term_if)
  );

  result_t pending_terms[$];
  int      fail_count;
  longint  cycle_count;
  bit      idling_on;
  int      ready_hold;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic signed [OUT_WIDTH-1:0] scaled_term(longint jump, longint w,
                                                              longint dn);
    logic signed [127:0] prod;
    logic [127:0]        m;
    logic [127:0]        lim;
    bit                  neg;
    prod = 128'(signed'(jump)) * 128'(signed'(w)) * 128'(signed'(dn));
    neg  = prod < 0;
    m    = neg ? 128'(-prod) : 128'(prod);
    m    = m >> TERM_SHIFT;
    lim  = neg ? (128'd1 << (OUT_WIDTH - 1)) : ((128'd1 << (OUT_WIDTH - 1)) - 1);
    if (m > lim) m = lim;
    return neg ? -m[OUT_WIDTH-1:0] : m[OUT_WIDTH-1:0];
  endfunction

  function automatic result_t predict_terms(edge_beat_t b);
    result_t r;
    longint  sx, sy, dx, dy, jump, dn, ua, ub, t, sq, wt, we, ws;
    longint  p[4];
    longint  q[4];
    r  = '0;
    sx = b.sx;
    sy = b.sy;
    dx = longint'(b.ex) - sx;
    dy = longint'(b.ey) - sy;
    if (dx == 0 && dy == 0) return r;
    p = '{-dx, dx, -dy, dy};
    q = '{sx, ONE - sx, sy, ONE - sy};
    ua = 0;
    ub = ONE;
    for (int i = 0; i < 4; i++) begin
      if (p[i] == 0) begin
        if (q[i] < 0) return r;
      end else begin
        t = (q[i] * ONE) / p[i];
        if (p[i] < 0) begin
          if (t > ua) ua = t;
        end else begin
          if (t < ub) ub = t;
        end
      end
    end
    if (ua >= ub) return r;
    sq   = ub * ub - ua * ua;
    wt   = ub - ua;
    we   = sq >>> (FRAC_BITS + 1);
    ws   = ((wt <<< (FRAC_BITS + 1)) - sq) >>> (FRAC_BITS + 1);
    jump = longint'(b.vin) - longint'(b.vout);
    dn   = longint'(b.diry) * dx - longint'(b.dirx) * dy;
    r.term_start_moving = scaled_term(jump, ws, dn);
    r.term_end_moving   = scaled_term(jump, we, dn);
    r.term_translating  = scaled_term(jump, wt, dn);
    r.crosses_pixel     = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [OUT_WIDTH-1:0] got,
                                 logic [OUT_WIDTH-1:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    fail_count++;
  endtask

  function automatic int random_gap();
    int roll;
    if (!idling_on) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ready_hold != 0) begin
        ready_hold    <= ready_hold - 1;
        term_if.ready <= 1'b0;
      end else begin
        ready_hold    <= random_gap();
        term_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && term_if.valid && term_if.ready) begin
      if (pending_terms.size() == 0) begin
        $display("result beat with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_terms.pop_front();
        if (term_if.term_start_moving !== want.term_start_moving)
          report_mismatch("term_start_moving", term_if.term_start_moving,
                          want.term_start_moving);
        if (term_if.term_end_moving !== want.term_end_moving)
          report_mismatch("term_end_moving", term_if.term_end_moving,
                          want.term_end_moving);
        if (term_if.term_translating !== want.term_translating)
          report_mismatch("term_translating", term_if.term_translating,
                          want.term_translating);
        if (term_if.crosses_pixel !== want.crosses_pixel)
          report_mismatch("crosses_pixel", OUT_WIDTH'(term_if.crosses_pixel),
                          OUT_WIDTH'(want.crosses_pixel));
      end
    end
  end

  task automatic send_edge(edge_beat_t b);
    int gap;
    gap = random_gap();
    if (gap > 0) begin
      edge_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    edge_if.valid         <= 1'b1;
    edge_if.start_x       <= b.sx;
    edge_if.start_y       <= b.sy;
    edge_if.end_x         <= b.ex;
    edge_if.end_y         <= b.ey;
    edge_if.dir_x         <= b.dirx;
    edge_if.dir_y         <= b.diry;
    edge_if.inside_value  <= b.vin;
    edge_if.outside_value <= b.vout;
    @(posedge clk_i);
    while (!edge_if.ready) @(posedge clk_i);
    pending_terms.push_back(predict_terms(b));
  endtask

  task automatic wait_drained();
    edge_if.valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] any_value();
    return COORD_WIDTH'($urandom);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] near_pixel();
    return COORD_WIDTH'($signed($urandom_range(4 * ONE)) - 2 * ONE + ONE / 2);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] modest_value();
    return COORD_WIDTH'($signed($urandom_range(8 * ONE)) - 4 * ONE);
  endfunction

  function automatic edge_beat_t make_beat(longint sx, longint sy, longint ex, longint ey,
                                           longint dirx, longint diry, longint vin,
                                           longint vout);
    edge_beat_t b;
    b.sx   = COORD_WIDTH'(sx);
    b.sy   = COORD_WIDTH'(sy);
    b.ex   = COORD_WIDTH'(ex);
    b.ey   = COORD_WIDTH'(ey);
    b.dirx = COORD_WIDTH'(dirx);
    b.diry = COORD_WIDTH'(diry);
    b.vin  = COORD_WIDTH'(vin);
    b.vout = COORD_WIDTH'(vout);
    return b;
  endfunction

  task automatic test_directed();
    longint mx;
    longint mn;
    mx = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    mn = -(64'sd1 <<< (COORD_WIDTH - 1));
    idling_on = 1'b0;
    // Degenerate edge, then parallel edges lying outside each side.
    send_edge(make_beat(ONE / 2, ONE / 2, ONE / 2, ONE / 2, ONE, ONE, ONE, 0));
    send_edge(make_beat(-ONE / 4, 0, -ONE / 4, ONE, ONE, 0, ONE, 0));
    send_edge(make_beat(ONE + 5, 0, ONE + 5, ONE, ONE, 0, ONE, 0));
    send_edge(make_beat(0, -3, ONE, -3, 0, ONE, ONE, 0));
    send_edge(make_beat(0, 2 * ONE, ONE, 2 * ONE, 0, ONE, ONE, 0));
    // Chords through the pixel in both directions.
    send_edge(make_beat(-ONE, ONE / 2, 2 * ONE, ONE / 2, 0, ONE, ONE, -ONE));
    send_edge(make_beat(2 * ONE, ONE / 2, -ONE, ONE / 2, 0, -ONE, -ONE, ONE));
    send_edge(make_beat(0, 0, ONE, ONE, ONE, -ONE, 3 * ONE, ONE));
    send_edge(make_beat(ONE / 4, ONE / 4, ONE / 2, 3 * ONE / 4, ONE, ONE, ONE, 0));
    send_edge(make_beat(ONE / 2, -ONE, ONE / 2, 2 * ONE, ONE, 0, ONE, ONE));
    // Chords missing the pixel, and a corner graze that still leaves a short chord.
    send_edge(make_beat(2 * ONE, -ONE, 3 * ONE, 2 * ONE, ONE, ONE, ONE, 0));
    send_edge(make_beat(-ONE, 1, 1, -ONE, ONE, ONE, ONE, 0));
    send_edge(make_beat(ONE - 1, 0, ONE + 7, 3, ONE, ONE, ONE, 0));
    // Field extremes and saturation, then a degenerate edge, a zero direction and a zero jump.
    send_edge(make_beat(mn, mn, mx, mx, mx, mn, mx, mn));
    send_edge(make_beat(mx, mn, mn, mx, mn, mx, mn, mx));
    send_edge(make_beat(mn, ONE / 2, mx, ONE / 2, mn, mn, mx, mn));
    send_edge(make_beat(ONE / 2, mx, ONE / 2, mn, mx, mx, mn, mx));
    send_edge(make_beat(-1, -1, -1, -1, -1, -1, -1, -1));
    send_edge(make_beat(0, 0, ONE, 0, 0, 0, ONE, 0));
    send_edge(make_beat(0, ONE / 2, ONE, ONE / 2, ONE, ONE, ONE, ONE));
    wait_drained();
  endtask

  task automatic test_random_chords(int count);
    edge_beat_t b;
    idling_on = 1'b1;
    for (int i = 0; i < count; i++) begin
      b.sx   = near_pixel();
      b.sy   = near_pixel();
      b.ex   = near_pixel();
      b.ey   = near_pixel();
      b.dirx = modest_value();
      b.diry = modest_value();
      b.vin  = modest_value();
      b.vout = modest_value();
      if ($urandom_range(9) == 0) b.ex = b.sx;
      if ($urandom_range(9) == 0) b.ey = b.sy;
      if ($urandom_range(7) == 0) begin
        b.vin  = any_value();
        b.dirx = any_value();
        b.diry = any_value();
      end
      send_edge(b);
      if (i == count / 2) begin
        wait_drained();
        idling_on = 1'b0;
      end
    end
    wait_drained();
  endtask

  task automatic test_random_noise(int count);
    edge_beat_t b;
    idling_on = 1'b1;
    for (int i = 0; i < count; i++) begin
      b.sx   = any_value();
      b.sy   = any_value();
      b.ex   = any_value();
      b.ey   = any_value();
      b.dirx = any_value();
      b.diry = any_value();
      b.vin  = any_value();
      b.vout = any_value();
      send_edge(b);
    end
    wait_drained();
  endtask

  initial begin
    fail_count          = 0;
    cycle_count         = 0;
    idling_on           = 1'b0;
    ready_hold          = 0;
    rst_ni              = 1'b0;
    edge_if.valid         = 1'b0;
    edge_if.start_x       = '0;
    edge_if.start_y       = '0;
    edge_if.end_x         = '0;
    edge_if.end_y         = '0;
    edge_if.dir_x         = '0;
    edge_if.dir_y         = '0;
    edge_if.inside_value  = '0;
    edge_if.outside_value = '0;
    term_if.ready         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_chords(340);
    test_random_noise(90);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending_terms.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: edge_pixel_boundary_term_core.f
rtl/epbt_pkg.sv
rtl/epbt_edge_if.sv
rtl/epbt_term_if.sv
rtl/epbt_div_lane.sv
rtl/epbt_term_mul.sv
rtl/epbt_out_buf.sv
rtl/edge_pixel_boundary_term_core.sv
tb/edge_pixel_boundary_term_core_tb.sv
